[rtl/cubic_trajectory_interpolator_assert.svh]
// Assertion macros for the checker file of the interpolator.
`ifndef CUBIC_TRAJECTORY_INTERPOLATOR_ASSERT_SVH
`define CUBIC_TRAJECTORY_INTERPOLATOR_ASSERT_SVH

// Clocked assertion, muted while reset is asserted
`define CTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define CTI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cti_pkg.sv]
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants of the cubic trajectory interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int VAL_W          = 32;
    localparam int CFG_IDX_W      = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 8'd3;

    // Per-stage control travelling along the pipeline
    typedef struct packed {
        logic valid;
        logic bypass;
    } ctl_t;

endpackage

[rtl/cti_div_cell.sv]
// ----------------------------------------------------------------------------
// cti_div_cell
// One restoring-division cell: doubles the remainder, produces one quotient
// bit, and hands the request to the next cell.
// ----------------------------------------------------------------------------
module cti_div_cell
    import cti_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  in_ctl,
    output logic                  in_ready,
    input  logic [VAL_W-1:0]      in_rem,
    input  logic [VAL_W-1:0]      in_div,
    input  logic [PHASE_BITS:0]   in_quo,
    input  logic [VAL_W-1:0]      in_bval,
    output ctl_t                  out_ctl,
    input  logic                  out_ready,
    output logic [VAL_W-1:0]      out_rem,
    output logic [VAL_W-1:0]      out_div,
    output logic [PHASE_BITS:0]   out_quo,
    output logic [VAL_W-1:0]      out_bval
);

    ctl_t                ctl_reg;
    logic [VAL_W-1:0]    rem_reg, rem_next;
    logic [VAL_W-1:0]    div_reg;
    logic [PHASE_BITS:0] quo_reg, quo_next;
    logic [VAL_W-1:0]    bval_reg;
    logic [VAL_W:0]      rem2;
    logic [VAL_W:0]      diff;
    logic                ge;

    // Take a new request when empty or when the next cell drains this one
    assign in_ready = !ctl_reg.valid || out_ready;

    // Shift, compare and conditionally subtract
    always_comb
    begin
        rem2     = {in_rem, 1'b0};
        diff     = rem2 - {1'b0, in_div};
        ge       = !diff[VAL_W];
        rem_next = ge ? diff[VAL_W-1:0] : rem2[VAL_W-1:0];
        quo_next = {in_quo[PHASE_BITS-1:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg <= in_ctl;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quo_reg  <= quo_next;
            bval_reg <= in_bval;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_rem  = rem_reg;
    assign out_div  = div_reg;
    assign out_quo  = quo_reg;
    assign out_bval = bval_reg;

endmodule

[rtl/cti_poly.sv]
// ----------------------------------------------------------------------------
// cti_poly
// Blend pipeline: s^2, s^3, 3s^2-2s^3 times the span, then the final add;
// bypassed samples leave with their input value.
module cti_poly
    import cti_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    in_ctl,
    output logic                    in_ready,
    input  logic [PHASE_BITS:0]     in_phase,
    input  logic [VAL_W-1:0]        in_bval,
    input  logic signed [VAL_W-1:0] start_value,
    input  logic signed [VAL_W-1:0] end_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [VAL_W-1:0]        out_data
);

    localparam int SW = PHASE_BITS + 1;
    localparam int PW = VAL_W + 1 + PHASE_BITS + 2;
    localparam logic [SW-1:0] ONE = SW'(1) << PHASE_BITS;

    ctl_t a_ctl_reg, b_ctl_reg, c_ctl_reg;
    logic d_vld_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy;

    logic [SW-1:0]           a_s_reg, a_s2_reg, b_s2_reg, b_s3_reg;
    logic [VAL_W-1:0]        a_bv_reg, b_bv_reg, c_bv_reg;
    logic signed [PW-1:0]    c_prod_reg;
    logic [VAL_W-1:0]        d_out_reg;

    logic [2*SW-1:0]         sq, cu;
    logic [SW+1:0]           hsum;
    logic [SW-1:0]           h;
    logic signed [VAL_W:0]   span;
    logic signed [PW-1:0]    prod_next, prod_sh;

    // Ready chain back from the output register
    assign d_rdy    = !d_vld_reg || out_ready;
    assign c_rdy    = !c_ctl_reg.valid || d_rdy;
    assign b_rdy    = !b_ctl_reg.valid || c_rdy;
    assign a_rdy    = !a_ctl_reg.valid || b_rdy;
    assign in_ready = a_rdy;

    always_comb
    begin
        sq        = (2*SW)'(in_phase) * (2*SW)'(in_phase);
        cu        = (2*SW)'(a_s2_reg) * (2*SW)'(a_s_reg);
        hsum      = ({2'b0, b_s2_reg} << 1) + {2'b0, b_s2_reg} - ({2'b0, b_s3_reg} << 1);
        h         = (hsum > {2'b0, ONE}) ? ONE : hsum[SW-1:0];
        span      = {end_value[VAL_W-1], end_value} - {start_value[VAL_W-1], start_value};
        prod_next = PW'(span) * $signed({1'b0, h});
        prod_sh   = c_prod_reg >>> PHASE_BITS;
    end

    // Advance control of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy) a_ctl_reg <= in_ctl;
            if (b_rdy) b_ctl_reg <= a_ctl_reg;
            if (c_rdy) c_ctl_reg <= b_ctl_reg;
            if (d_rdy) d_vld_reg <= c_ctl_reg.valid;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (a_rdy && in_ctl.valid)
        begin
            a_s_reg  <= in_phase;
            a_s2_reg <= sq[2*SW-2:PHASE_BITS];
            a_bv_reg <= in_bval;
        end
        if (b_rdy && a_ctl_reg.valid)
        begin
            b_s2_reg <= a_s2_reg;
            b_s3_reg <= cu[2*SW-2:PHASE_BITS];
            b_bv_reg <= a_bv_reg;
        end
        if (c_rdy && b_ctl_reg.valid)
        begin
            c_prod_reg <= b_ctl_reg.bypass ? '0 : prod_next;
            c_bv_reg   <= b_bv_reg;
        end
        if (d_rdy && c_ctl_reg.valid)
        begin
            d_out_reg <= c_ctl_reg.bypass ? c_bv_reg
                                          : start_value + prod_sh[VAL_W-1:0];
        end
    end

    assign out_valid = d_vld_reg;
    assign out_data  = d_out_reg;

endmodule

[rtl/cubic_trajectory_interpolator.sv]
// ----------------------------------------------------------------------------
// cubic_trajectory_interpolator
// Cubic set-point generator with zero end velocity over a time window.
// ----------------------------------------------------------------------------
// Usage:
//   Write start_time, end_time, start_value, end_value through the cfg port
//   (cfg_index 0..3, other indexes are dropped) while no request is in flight.
//   Send sample_time on s_tdata; the set-point (signed Q16.16) comes out on
//   m_tdata in the same order.
//   The divider chain holds one cell per quotient bit below the seeded top
//   bit, then four blend stages follow. One request per cycle is sustained
//   while m_tready is high; each division cell retires one quotient bit
//   per request.
//   Samples outside the window, or a zero-length window, ride through the
//   same stages with their value chosen at the input.
//   Reset clears all configuration registers to zero and empties the
//   pipeline. When the receiver stalls, each stage holds its request and
//   s_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module cubic_trajectory_interpolator
    import cti_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VAL_W-1:0]     s_tdata,   // [31:0] sample_time
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VAL_W-1:0]     m_tdata    // [31:0] set_point
);

    logic [VAL_W-1:0] start_time_reg, end_time_reg;
    logic [VAL_W-1:0] start_value_reg, end_value_reg;

    ctl_t                c_ctl  [0:PHASE_BITS];
    logic                c_rdy  [0:PHASE_BITS];
    logic [VAL_W-1:0]    c_rem  [0:PHASE_BITS];
    logic [VAL_W-1:0]    c_div  [0:PHASE_BITS];
    logic [PHASE_BITS:0] c_quo  [0:PHASE_BITS];
    logic [VAL_W-1:0]    c_bval [0:PHASE_BITS];

    logic [VAL_W-1:0] elapsed, span_t;
    logic             early, after, top_bit;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg  <= '0;
            end_time_reg    <= '0;
            start_value_reg <= '0;
            end_value_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_TIME:  start_time_reg  <= cfg_data;
                REG_END_TIME:    end_time_reg    <= cfg_data;
                REG_START_VALUE: start_value_reg <= cfg_data;
                REG_END_VALUE:   end_value_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Classify the sample and seed the divider
    always_comb
    begin
        early   = s_tdata < start_time_reg;
        after   = s_tdata > end_time_reg;
        elapsed = s_tdata - start_time_reg;
        span_t  = end_time_reg - start_time_reg;
        top_bit = elapsed == span_t;
        c_ctl[0].valid  = s_tvalid;
        c_ctl[0].bypass = early || after || (end_time_reg == start_time_reg);
        c_bval[0] = early ? start_value_reg : end_value_reg;
        c_rem[0]  = top_bit ? '0 : elapsed;
        c_div[0]  = span_t;
        c_quo[0]  = {{PHASE_BITS{1'b0}}, top_bit};
    end

    assign s_tready = c_rdy[0];

    // Division chain, one quotient bit per cell
    for (genvar i = 0; i < PHASE_BITS; i++)
    begin : g_cell
        cti_div_cell #(
            .PHASE_BITS (PHASE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_ctl    (c_ctl[i]),
            .in_ready  (c_rdy[i]),
            .in_rem    (c_rem[i]),
            .in_div    (c_div[i]),
            .in_quo    (c_quo[i]),
            .in_bval   (c_bval[i]),
            .out_ctl   (c_ctl[i+1]),
            .out_ready (c_rdy[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_div   (c_div[i+1]),
            .out_quo   (c_quo[i+1]),
            .out_bval  (c_bval[i+1])
        );
    end

    // Blend and output
    cti_poly #(
        .PHASE_BITS (PHASE_BITS)
    ) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ctl      (c_ctl[PHASE_BITS]),
        .in_ready    (c_rdy[PHASE_BITS]),
        .in_phase    (c_quo[PHASE_BITS]),
        .in_bval     (c_bval[PHASE_BITS]),
        .start_value (start_value_reg),
        .end_value   (end_value_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // Remainder and divisor leave the last cell unused
    logic unused_tail;
    assign unused_tail = ^{c_rem[PHASE_BITS], c_div[PHASE_BITS]};

endmodule

[rtl/cti_checker.sv]
// ----------------------------------------------------------------------------
// cti_checker
// Port-level assertions of the cubic trajectory interpolator.
// ----------------------------------------------------------------------------
`include "cubic_trajectory_interpolator_assert.svh"

module cti_checker
    import cti_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_ready,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [VAL_W-1:0]     m_tdata
);

    // Hold a stalled result
    `CTI_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    // Drained output lets the whole pipeline move
    `CTI_ASSERT(a_ready_flow, m_tready |-> s_tready, "input stalled with receiver ready")
    // Configuration is never back-pressured
    `CTI_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")
    // Stalled result keeps its value
    `CTI_ASSERT(a_out_data, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

endmodule

bind cubic_trajectory_interpolator cti_checker u_cti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
